[rtl/rlbf_pkg.sv]
package rlbf_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_FLASH = 2'd1,
    CMD_APPLY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_STEADY = 2'd0,
    MODE_BLINK  = 2'd1,
    MODE_FLASH  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_RED       = 3'd0,
    REG_GREEN     = 3'd1,
    REG_BLUE      = 3'd2,
    REG_BRIGHT    = 3'd3,
    REG_BLINK_ON  = 3'd4,
    REG_BLINK_OFF = 3'd5
  } reg_idx_t;

  localparam int unsigned BRIGHT_RESET = 50;
  // 2^19 / 100 rounded up; exact floor for every 8 by 7 bit product
  localparam logic [19:0] BRIGHT_RECIP = 20'd5243;
  localparam int unsigned BRIGHT_SHIFT = 19;
  localparam int unsigned FACTOR_W = 20;
  localparam int unsigned PROD_W = 28;

  typedef struct packed {
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [FACTOR_W-1:0] factor;
    logic [15:0]         on_time;
    logic [15:0]         off_time;
  } cfg_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  flash_red;
    logic [7:0]  flash_green;
    logic [7:0]  flash_blue;
    logic [15:0] flash_ms;
  } item_t;

  // c * brightness / 100, saturated at 255
  function automatic logic [7:0] scale_chan(input logic [7:0] c,
                                            input logic [FACTOR_W-1:0] k);
    logic [PROD_W-1:0] p;
    logic [PROD_W-BRIGHT_SHIFT-1:0] v;
    p = PROD_W'(c) * PROD_W'(k);
    v = p[PROD_W-1:BRIGHT_SHIFT];
    if (v > (PROD_W-BRIGHT_SHIFT)'(255)) begin
      return 8'hFF;
    end
    return v[7:0];
  endfunction

endpackage

[rtl/rlbf_cfg.sv]
module rlbf_cfg
  import rlbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [6:0]  brightness;
  logic [FACTOR_W-1:0] factor;
  logic [15:0] on_time;
  logic [15:0] off_time;
  logic        wr;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      red          <= '0;
      green        <= '0;
      blue         <= '0;
      brightness   <= 7'(BRIGHT_RESET);
      factor       <= FACTOR_W'(BRIGHT_RESET) * BRIGHT_RECIP;
      on_time      <= '0;
      off_time     <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_RED:       red <= pwdata[7:0];
        REG_GREEN:     green <= pwdata[7:0];
        REG_BLUE:      blue <= pwdata[7:0];
        REG_BRIGHT: begin
          brightness <= pwdata[6:0];
          // keep the scale factor ready so the data path has one multiply
          factor     <= FACTOR_W'(pwdata[6:0]) * BRIGHT_RECIP;
        end
        REG_BLINK_ON:  on_time <= pwdata[15:0];
        REG_BLINK_OFF: off_time <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_RED:       prdata = 32'(red);
      REG_GREEN:     prdata = 32'(green);
      REG_BLUE:      prdata = 32'(blue);
      REG_BRIGHT:    prdata = 32'(brightness);
      REG_BLINK_ON:  prdata = 32'(on_time);
      REG_BLINK_OFF: prdata = 32'(off_time);
      default:       prdata = '0;
    endcase
  end

  assign cfg.red      = red;
  assign cfg.green    = green;
  assign cfg.blue     = blue;
  assign cfg.factor   = factor;
  assign cfg.on_time  = on_time;
  assign cfg.off_time = off_time;

endmodule

[rtl/rlbf_in.sv]
module rlbf_in
  import rlbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        take,
  output logic        full,
  output item_t       item
);

  logic full_next;

  assign s_tready = !full || take;

  always_comb begin
    full_next = full;
    if (s_tvalid && s_tready) begin
      full_next = 1'b1;
    end else if (take) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.command     <= cmd_t'(s_tuser);
      item.flash_red   <= s_tdata[7:0];
      item.flash_green <= s_tdata[15:8];
      item.flash_blue  <= s_tdata[23:16];
      item.flash_ms    <= s_tdata[39:24];
    end
  end

endmodule

[rtl/rlbf_core.sv]
module rlbf_core
  import rlbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        item_valid,
  input  item_t       item,
  output logic        take,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output mode_t       mode,
  output logic [15:0] countdown,
  output logic [15:0] saved_remaining
);

  typedef enum logic [1:0] {
    SHOW_KEEP  = 2'd0,
    SHOW_COLOR = 2'd1,
    SHOW_DARK  = 2'd2,
    SHOW_FLASH = 2'd3
  } show_t;

  logic        phase_on;
  logic [23:0] shown_pixel;
  mode_t       mode_next;
  logic        phase_on_next;
  logic [15:0] countdown_next;
  logic [15:0] saved_next;
  logic [23:0] pixel_next;
  logic        out_valid_next;
  logic        enabled;
  logic        run_setup;
  logic        expiry;
  logic [15:0] cd_dec;
  show_t       show_sel;
  logic [7:0]  pick_r;
  logic [7:0]  pick_g;
  logic [7:0]  pick_b;

  assign take    = item_valid && (!m_tvalid || m_tready);
  assign enabled = (cfg.on_time != '0) && (cfg.off_time != '0);
  assign cd_dec  = (countdown != '0) ? countdown - 16'd1 : '0;

  always_comb begin
    mode_next      = mode;
    phase_on_next  = phase_on;
    countdown_next = countdown;
    saved_next     = saved_remaining;
    run_setup      = 1'b0;
    expiry         = 1'b0;
    show_sel       = SHOW_KEEP;

    unique case (item.command)
      CMD_TICK: begin
        if (mode != MODE_STEADY) begin
          countdown_next = cd_dec;
          if (cd_dec == '0) begin
            run_setup = 1'b1;
            expiry    = 1'b1;
          end
        end
      end
      CMD_FLASH: begin
        if (mode != MODE_STEADY) begin
          saved_next = countdown;
        end
        show_sel       = SHOW_FLASH;
        countdown_next = item.flash_ms;
        mode_next      = MODE_FLASH;
      end
      CMD_APPLY: begin
        if (enabled) begin
          phase_on_next = 1'b0;
        end
        run_setup = 1'b1;
      end
      CMD_NONE: ;
      default: ;
    endcase

    if (run_setup) begin
      priority if (!enabled) begin
        mode_next      = MODE_STEADY;
        countdown_next = '0;
        saved_next     = '0;
        show_sel       = SHOW_COLOR;
      end else if (mode_next == MODE_BLINK) begin
        // apply while blinking keeps the countdown and pixel but clears the phase flag
        if (expiry) begin
          phase_on_next  = !phase_on_next;
          countdown_next = phase_on_next ? cfg.on_time : cfg.off_time;
          show_sel       = phase_on_next ? SHOW_COLOR : SHOW_DARK;
        end
      end else if (saved_next != '0) begin
        // resume the blink phase that the flash cut short
        countdown_next = saved_next;
        saved_next     = '0;
        mode_next      = MODE_BLINK;
        show_sel       = phase_on_next ? SHOW_COLOR : SHOW_DARK;
      end else begin
        countdown_next = cfg.on_time;
        mode_next      = MODE_BLINK;
        phase_on_next  = 1'b1;
        show_sel       = SHOW_COLOR;
      end
    end
  end

  always_comb begin
    pick_r = '0;
    pick_g = '0;
    pick_b = '0;
    unique case (show_sel)
      SHOW_COLOR: begin
        pick_r = cfg.red;
        pick_g = cfg.green;
        pick_b = cfg.blue;
      end
      SHOW_FLASH: begin
        pick_r = item.flash_red;
        pick_g = item.flash_green;
        pick_b = item.flash_blue;
      end
      SHOW_DARK, SHOW_KEEP: ;
      default: ;
    endcase
    if (show_sel == SHOW_KEEP) begin
      pixel_next = shown_pixel;
    end else begin
      pixel_next = {scale_chan(pick_r, cfg.factor), scale_chan(pick_g, cfg.factor),
                    scale_chan(pick_b, cfg.factor)};
    end
  end

  always_comb begin
    out_valid_next = m_tvalid;
    if (take) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  // state changes only when a word is taken, so it doubles as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_STEADY;
      phase_on        <= 1'b0;
      countdown       <= '0;
      saved_remaining <= '0;
      shown_pixel     <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      m_tvalid <= out_valid_next;
      if (take) begin
        mode            <= mode_next;
        phase_on        <= phase_on_next;
        countdown       <= countdown_next;
        saved_remaining <= saved_next;
        shown_pixel     <= pixel_next;
      end
    end
  end

  assign m_tdata = {6'd0, mode, shown_pixel[7:0], shown_pixel[15:8], shown_pixel[23:16]};

endmodule

[rtl/rgb_led_blink_flash_controller.sv]
// Drives one RGB pixel in steady, blink or flash mode from millisecond ticks,
// flash requests and apply commands, one result word per input word. A word
// is held first in the input register and then in the state update, whose
// registers also hold the result, so a new word is taken every cycle unless
// the result side stalls. Channels are scaled as c*brightness/100 through a
// factor precomputed at register write, so the data path carries a single
// 8 by 20 bit multiply per channel.
module rgb_led_blink_flash_controller
  import rlbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // flash_red, flash_green, flash_blue, flash_ms
  input  logic [1:0]  s_tuser,  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // pixel_red, pixel_green, pixel_blue, mode
);

  cfg_t        cfg;
  item_t       item;
  logic        item_valid;
  logic        take;
  mode_t       mode;
  logic [15:0] countdown;
  logic [15:0] saved_remaining;

  rlbf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlbf_in u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .take     (take),
    .full     (item_valid),
    .item     (item)
  );

  rlbf_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .item_valid      (item_valid),
    .item            (item),
    .take            (take),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mode            (mode),
    .countdown       (countdown),
    .saved_remaining (saved_remaining)
  );

  // input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without result backpressure");

  // a blink phase always has time left; expiry reloads it in the same step
  a_blink_count: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_BLINK) |-> (countdown != '0))
    else $error("blink mode with empty countdown");

  // saved blink time exists only while a flash runs
  a_saved_flash: assert property (@(posedge clk) disable iff (rst)
    (saved_remaining != '0) |-> (mode == MODE_FLASH))
    else $error("saved time outside flash mode");

endmodule

[verif/rgb_led_blink_flash_controller_tb.sv]
module rgb_led_blink_flash_controller_tb;
  import rlbf_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    mode_t      mode;
  } px_t;

  typedef struct {
    bit          is_reg;
    reg_idx_t    ridx;
    logic [15:0] rval;
    cmd_t        cmd;
    logic [7:0]  fr;
    logic [7:0]  fg;
    logic [7:0]  fb;
    logic [15:0] fms;
    bit          has_exp;
    px_t         exp_px;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;  // flash_red, flash_green, flash_blue, flash_ms
  logic [1:0]  s_tuser;  // command
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;  // pixel_red, pixel_green, pixel_blue, mode

  rgb_led_blink_flash_controller u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // register copies
  logic [7:0]  cfg_red;
  logic [7:0]  cfg_green;
  logic [7:0]  cfg_blue;
  logic [6:0]  cfg_bright;
  logic [15:0] cfg_on;
  logic [15:0] cfg_off;

  // pixel state
  mode_t       st_mode;
  logic        st_phase;
  logic [15:0] st_count;
  logic [15:0] st_saved;
  logic [7:0]  px_r;
  logic [7:0]  px_g;
  logic [7:0]  px_b;

  px_t         pending_px[$];
  dir_row_t    dir_rows[$];
  int          mismatches;
  int          words_sent;
  int          words_checked;
  int          reg_writes;
  int          src_idle_pct;
  int          snk_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [7:0] pct_scale(input logic [7:0] c);
    int unsigned v;
    v = (int'(c) * int'(cfg_bright)) / 100;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic void paint(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b);
    px_r = pct_scale(r);
    px_g = pct_scale(g);
    px_b = pct_scale(b);
  endfunction

  function automatic void paint_phase();
    if (st_phase) begin
      paint(cfg_red, cfg_green, cfg_blue);
    end else begin
      paint(8'h00, 8'h00, 8'h00);
    end
  endfunction

  // enter, continue or leave blinking after an expiry or an apply
  function automatic void resume_blink(input bit expiry);
    if (cfg_on == 16'd0 || cfg_off == 16'd0) begin
      st_mode  = MODE_STEADY;
      st_count = 16'd0;
      st_saved = 16'd0;
      paint(cfg_red, cfg_green, cfg_blue);
    end else if (st_mode == MODE_BLINK) begin
      if (expiry) begin
        st_phase = ~st_phase;
        st_count = st_phase ? cfg_on : cfg_off;
        paint_phase();
      end
    end else if (st_saved != 16'd0) begin
      st_count = st_saved;
      st_saved = 16'd0;
      st_mode  = MODE_BLINK;
      paint_phase();
    end else begin
      st_count = cfg_on;
      st_mode  = MODE_BLINK;
      st_phase = 1'b1;
      paint_phase();
    end
  endfunction

  function automatic px_t step_pixel(input cmd_t c, input logic [39:0] d);
    px_t p;
    case (c)
      CMD_TICK: begin
        if (st_mode != MODE_STEADY) begin
          if (st_count != 16'd0) st_count = st_count - 16'd1;
          if (st_count == 16'd0) resume_blink(1'b1);
        end
      end
      CMD_FLASH: begin
        // a flash over a flash saves the earlier flash's countdown too
        if (st_mode != MODE_STEADY) st_saved = st_count;
        paint(d[7:0], d[15:8], d[23:16]);
        st_count = d[39:24];
        st_mode  = MODE_FLASH;
      end
      CMD_APPLY: begin
        if (cfg_on != 16'd0 && cfg_off != 16'd0) st_phase = 1'b0;
        resume_blink(1'b0);
      end
      default: ;
    endcase
    p.red   = px_r;
    p.green = px_g;
    p.blue  = px_b;
    p.mode  = st_mode;
    return p;
  endfunction

  function automatic dir_row_t item_row(input cmd_t c, input logic [7:0] fr,
                                        input logic [7:0] fg, input logic [7:0] fb,
                                        input logic [15:0] fms);
    dir_row_t r;
    r.is_reg  = 1'b0;
    r.ridx    = REG_RED;
    r.rval    = 16'd0;
    r.cmd     = c;
    r.fr      = fr;
    r.fg      = fg;
    r.fb      = fb;
    r.fms     = fms;
    r.has_exp = 1'b0;
    r.exp_px  = '0;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input reg_idx_t idx, input logic [15:0] v);
    dir_row_t r;
    r = item_row(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'd0);
    r.is_reg = 1'b1;
    r.ridx   = idx;
    r.rval   = v;
    return r;
  endfunction

  function automatic dir_row_t chk_row(input cmd_t c, input logic [15:0] fms,
                                       input logic [7:0] er, input logic [7:0] eg,
                                       input logic [7:0] eb, input mode_t em);
    dir_row_t r;
    r = item_row(c, 8'hFF, 8'hFF, 8'hFF, fms);
    r.has_exp = 1'b1;
    r.exp_px  = '{er, eg, eb, em};
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input cmd_t c, input logic [39:0] d, input bit has_exp,
                           input px_t exp_px);
    px_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = step_pixel(c, d);
    pending_px.push_back(has_exp ? exp_px : pred);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_RED:       cfg_red    = v[7:0];
      REG_GREEN:     cfg_green  = v[7:0];
      REG_BLUE:      cfg_blue   = v[7:0];
      REG_BRIGHT:    cfg_bright = v[6:0];
      REG_BLINK_ON:  cfg_on     = v;
      REG_BLINK_OFF: cfg_off    = v;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // drop valid, let every expected word come back, then cover the pipeline
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_blink();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 15) return 16'($urandom);
    return 16'($urandom_range(6, 1));
  endfunction

  task automatic shuffle_regs();
    int unsigned r;
    logic [6:0] b;
    r = $urandom_range(7);
    if (r == 0) b = 7'd0;
    else if (r == 1) b = 7'($urandom_range(127, 101));
    else b = 7'($urandom_range(100, 1));
    write_reg(REG_RED, 16'($urandom_range(255)));
    write_reg(REG_GREEN, 16'($urandom_range(255)));
    write_reg(REG_BLUE, 16'($urandom_range(255)));
    write_reg(REG_BRIGHT, {9'd0, b});
    write_reg(REG_BLINK_ON, pick_blink());
    write_reg(REG_BLINK_OFF, pick_blink());
  endtask

  task automatic run_random(input int n);
    int unsigned r;
    cmd_t        c;
    logic [15:0] ms;
    for (int i = 0; i < n; i++) begin
      if (i % 70 == 0) begin
        settle();
        shuffle_regs();
      end
      r = $urandom_range(99);
      if (r < 55) c = CMD_TICK;
      else if (r < 75) c = CMD_FLASH;
      else if (r < 93) c = CMD_APPLY;
      else c = CMD_NONE;
      ms = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(6));
      send_word(c, {ms, 24'($urandom)}, 1'b0, '0);
    end
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    px_t want;
    px_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], mode_t'(m_tdata[25:24])};
      if (pending_px.size() == 0) begin
        $error("result word %h with nothing expected", m_tdata);
        mismatches++;
      end else begin
        want = pending_px.pop_front();
        words_checked++;
        if (got.red !== want.red) begin
          $error("pixel_red: expected %0h, got %0h", want.red, got.red);
          mismatches++;
        end
        if (got.green !== want.green) begin
          $error("pixel_green: expected %0h, got %0h", want.green, got.green);
          mismatches++;
        end
        if (got.blue !== want.blue) begin
          $error("pixel_blue: expected %0h, got %0h", want.blue, got.blue);
          mismatches++;
        end
        if (got.mode !== want.mode) begin
          $error("mode: expected %0d, got %0d", want.mode, got.mode);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_TICK;
    cfg_red    = 8'h00;
    cfg_green  = 8'h00;
    cfg_blue   = 8'h00;
    cfg_bright = 7'(BRIGHT_RESET);
    cfg_on     = 16'd0;
    cfg_off    = 16'd0;
    st_mode    = MODE_STEADY;
    st_phase   = 1'b0;
    st_count   = 16'd0;
    st_saved   = 16'd0;
    px_r = 8'h00;
    px_g = 8'h00;
    px_b = 8'h00;
    mismatches    = 0;
    words_sent    = 0;
    words_checked = 0;
    reg_writes    = 0;
    src_idle_pct  = 10;
    snk_idle_pct  = 87;

    // reset state, saturation, dark and full scale, flash expiry and resume
    dir_rows.push_back(chk_row(CMD_TICK, 16'd0, 8'h00, 8'h00, 8'h00, MODE_STEADY));
    dir_rows.push_back(chk_row(CMD_NONE, 16'd0, 8'h00, 8'h00, 8'h00, MODE_STEADY));
    dir_rows.push_back(chk_row(CMD_FLASH, 16'd0, 8'h7F, 8'h7F, 8'h7F, MODE_FLASH));
    dir_rows.push_back(chk_row(CMD_TICK, 16'd0, 8'h00, 8'h00, 8'h00, MODE_STEADY));
    dir_rows.push_back(reg_row(REG_RED, 16'h00FF));
    dir_rows.push_back(reg_row(REG_GREEN, 16'h0000));
    dir_rows.push_back(reg_row(REG_BLUE, 16'h0080));
    dir_rows.push_back(reg_row(REG_BRIGHT, 16'd100));
    dir_rows.push_back(chk_row(CMD_APPLY, 16'd0, 8'hFF, 8'h00, 8'h80, MODE_STEADY));
    dir_rows.push_back(reg_row(REG_BRIGHT, 16'd127));
    dir_rows.push_back(chk_row(CMD_APPLY, 16'd0, 8'hFF, 8'h00, 8'hA2, MODE_STEADY));
    dir_rows.push_back(reg_row(REG_BRIGHT, 16'd0));
    dir_rows.push_back(chk_row(CMD_FLASH, 16'hFFFF, 8'h00, 8'h00, 8'h00, MODE_FLASH));
    dir_rows.push_back(reg_row(REG_BRIGHT, 16'd1));
    dir_rows.push_back(chk_row(CMD_APPLY, 16'd0, 8'h02, 8'h00, 8'h01, MODE_STEADY));
    dir_rows.push_back(reg_row(REG_BRIGHT, 16'd100));
    dir_rows.push_back(reg_row(REG_BLINK_ON, 16'd2));
    dir_rows.push_back(reg_row(REG_BLINK_OFF, 16'd1));
    dir_rows.push_back(chk_row(CMD_APPLY, 16'd0, 8'hFF, 8'h00, 8'h80, MODE_BLINK));
    dir_rows.push_back(item_row(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(item_row(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(item_row(CMD_FLASH, 8'h12, 8'h34, 8'h56, 16'd2));
    dir_rows.push_back(item_row(CMD_FLASH, 8'hAB, 8'hCD, 8'hEF, 16'd0));
    dir_rows.push_back(item_row(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(item_row(CMD_APPLY, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(item_row(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(item_row(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(item_row(CMD_FLASH, 8'h00, 8'h00, 8'h00, 16'd1));
    dir_rows.push_back(item_row(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(item_row(CMD_FLASH, 8'hFF, 8'hFF, 8'hFF, 16'd3));
    dir_rows.push_back(item_row(CMD_APPLY, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(reg_row(REG_BLINK_OFF, 16'd0));
    dir_rows.push_back(item_row(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(item_row(CMD_APPLY, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(reg_row(REG_BLINK_ON, 16'hFFFF));
    dir_rows.push_back(reg_row(REG_BLINK_OFF, 16'hFFFF));
    dir_rows.push_back(item_row(CMD_APPLY, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(item_row(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'd0));
    dir_rows.push_back(item_row(CMD_FLASH, 8'h00, 8'h00, 8'h00, 16'hFFFF));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        settle();
        write_reg(dir_rows[i].ridx, dir_rows[i].rval);
      end else begin
        send_word(dir_rows[i].cmd,
                  {dir_rows[i].fms, dir_rows[i].fb, dir_rows[i].fg, dir_rows[i].fr},
                  dir_rows[i].has_exp, dir_rows[i].exp_px);
      end
    end

    run_random(345);
    settle();
    src_idle_pct = 87;
    snk_idle_pct = 10;
    run_random(345);
    settle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(345);
    settle();
    repeat (8) @(posedge clk);

    $display("Sent %0d words (ticks, flashes, applies, unused code) under %0d register writes,",
             words_sent, reg_writes);
    $display("checked %0d pixel words across three idling patterns, %0d mismatches.",
             words_checked, mismatches);
    if (mismatches == 0 && pending_px.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rlbf_pkg.sv
rtl/rlbf_cfg.sv
rtl/rlbf_in.sv
rtl/rlbf_core.sv
rtl/rgb_led_blink_flash_controller.sv
verif/rgb_led_blink_flash_controller_tb.sv
